@@ src/lkc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// LRU keyed entry cache package
// Shared types, constants and helpers for the cache directory.
// ----------------------------------------------------------------------------
package lkc_pkg;

    localparam int SLOTS_DEFAULT = 32;

    localparam int CFG_W      = 5;
    localparam int OUT_SLOT_W = 5;
    localparam int KIND_W     = 8;
    localparam int SEED_W     = 64;
    localparam int WIDTH_IN_W = 16;
    localparam int WIDTH_W    = 12;
    localparam int HEIGHT_W   = 11;
    localparam int STAMP_W    = 64;

    localparam logic [CFG_W-1:0]      MAX_ENTRIES_RESET = 5'd16;
    localparam logic [WIDTH_IN_W-1:0] WIDTH_MIN         = 16'd64;
    localparam logic [WIDTH_IN_W-1:0] WIDTH_MAX         = 16'd2048;

    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_CLEAR  = 1'b1;

    // One stored entry; the map bit and valid bit live in flip-flops.
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [SEED_W-1:0]  seed;
        logic [WIDTH_W-1:0] width;
        logic [STAMP_W-1:0] stamp;
    } entry_t;

    typedef struct packed {
        logic                  hit;
        logic [OUT_SLOT_W-1:0] slot;
        logic                  kept;
        logic                  evicted;
        logic [OUT_SLOT_W-1:0] evicted_slot;
        logic [WIDTH_W-1:0]    width_used;
        logic [HEIGHT_W-1:0]   height_used;
    } result_t;

    function automatic logic [WIDTH_W-1:0] clamp_width(input logic [WIDTH_IN_W-1:0] w);
        logic [WIDTH_IN_W-1:0] c;
        begin
            c = w;
            if (w < WIDTH_MIN) c = WIDTH_MIN;
            if (w > WIDTH_MAX) c = WIDTH_MAX;
            return c[WIDTH_W-1:0];
        end
    endfunction

endpackage
`default_nettype wire

@@ src/lkc_store.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Entry store
// Synchronous single-port-read, single-port-write memory holding the key
// fields and use stamp of every slot. Read data is registered.
// ----------------------------------------------------------------------------
module lkc_store #(
    parameter int STORE_SLOTS = lkc_pkg::SLOTS_DEFAULT,
    parameter int IDX_W       = $clog2(STORE_SLOTS)
) (
    input  wire logic                 clk,
    input  wire logic                 rd_en,
    input  wire logic [IDX_W-1:0]     rd_addr,
    output lkc_pkg::entry_t           rd_data,
    input  wire logic                 wr_en,
    input  wire logic [IDX_W-1:0]     wr_addr,
    input  wire lkc_pkg::entry_t      wr_data
);
    import lkc_pkg::*;

    entry_t mem [STORE_SLOTS];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

@@ src/lkc_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Cache controller
// Holds the valid and map bits, scans the entry store one slot per cycle for
// a match, the map's fill count and its oldest entry, then evicts, inserts
// or stamps the entry, or flushes the map at a zero limit, and produces the result.
// ----------------------------------------------------------------------------
module lkc_ctrl #(
    parameter int STORE_SLOTS = lkc_pkg::SLOTS_DEFAULT,
    parameter int IDX_W       = $clog2(STORE_SLOTS)
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic                            req_type,
    input  wire logic                            map_select,
    input  wire logic [lkc_pkg::KIND_W-1:0]      surface_kind,
    input  wire logic [lkc_pkg::SEED_W-1:0]      seed,
    input  wire logic [lkc_pkg::WIDTH_IN_W-1:0]  width_px,
    input  wire logic [lkc_pkg::CFG_W-1:0]       max_entries,
    output logic                                 done,
    output lkc_pkg::result_t                     res,
    output logic                                 rd_en,
    output logic [IDX_W-1:0]                     rd_addr,
    input  wire lkc_pkg::entry_t                 rd_data,
    output logic                                 wr_en,
    output logic [IDX_W-1:0]                     wr_addr,
    output lkc_pkg::entry_t                      wr_data
);
    import lkc_pkg::*;

    localparam int IW    = $clog2(STORE_SLOTS + 1);
    localparam int LIM_W = (IW > CFG_W) ? IW : CFG_W;
    localparam logic [IW-1:0]    SLOTS_IW = IW'(STORE_SLOTS);
    localparam logic [LIM_W-1:0] HALF_LIM = LIM_W'(STORE_SLOTS / 2);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_WRITE = 2'd2;

    logic [1:0]             state_reg, state_next;
    logic [STORE_SLOTS-1:0] valid_reg, valid_next;
    logic [STORE_SLOTS-1:0] map_reg, map_next;
    logic [STAMP_W-1:0]     tick_reg, tick_next;

    logic                   req_map_reg, req_map_next;
    logic [KIND_W-1:0]      req_kind_reg, req_kind_next;
    logic [SEED_W-1:0]      req_seed_reg, req_seed_next;
    logic [WIDTH_W-1:0]     req_width_reg, req_width_next;

    logic [IW-1:0]          issue_reg, issue_next;
    logic                   pend_reg, pend_next;
    logic [IDX_W-1:0]       pend_idx_reg, pend_idx_next;
    logic                   first_pass_reg, first_pass_next;
    logic                   found_reg, found_next;
    logic [IDX_W-1:0]       found_idx_reg, found_idx_next;
    logic [LIM_W-1:0]       count_reg, count_next;
    logic                   free_found_reg, free_found_next;
    logic [IDX_W-1:0]       free_idx_reg, free_idx_next;
    logic                   old_found_reg, old_found_next;
    logic [IDX_W-1:0]       old_idx_reg, old_idx_next;
    logic [STAMP_W-1:0]     old_stamp_reg, old_stamp_next;
    logic                   hit_reg, hit_next;
    logic                   evicted_reg, evicted_next;
    logic [IDX_W-1:0]       target_reg, target_next;
    logic                   done_reg, done_next;
    result_t                res_reg, res_next;

    logic [LIM_W-1:0]       me_ext;
    logic [LIM_W-1:0]       limit;
    logic                   scan_end;
    logic                   slot_in_map;
    logic [WIDTH_W-1:0]     clamped;

    assign me_ext   = LIM_W'(max_entries);
    assign limit    = (me_ext > HALF_LIM) ? HALF_LIM : me_ext;
    assign scan_end = (issue_reg == SLOTS_IW) && !pend_reg;
    assign clamped  = clamp_width(width_px);
    assign slot_in_map = valid_reg[pend_idx_reg] && (map_reg[pend_idx_reg] == req_map_reg);

    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        map_next        = map_reg;
        tick_next       = tick_reg;
        req_map_next    = req_map_reg;
        req_kind_next   = req_kind_reg;
        req_seed_next   = req_seed_reg;
        req_width_next  = req_width_reg;
        issue_next      = issue_reg;
        pend_next       = 1'b0;
        pend_idx_next   = pend_idx_reg;
        first_pass_next = first_pass_reg;
        found_next      = found_reg;
        found_idx_next  = found_idx_reg;
        count_next      = count_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        old_found_next  = old_found_reg;
        old_idx_next    = old_idx_reg;
        old_stamp_next  = old_stamp_reg;
        hit_next        = hit_reg;
        evicted_next    = evicted_reg;
        target_next     = target_reg;
        done_next       = 1'b0;
        res_next        = res_reg;
        rd_en           = 1'b0;
        rd_addr         = issue_reg[IDX_W-1:0];
        wr_en           = 1'b0;
        wr_addr         = target_reg;
        wr_data.kind    = req_kind_reg;
        wr_data.seed    = req_seed_reg;
        wr_data.width   = req_width_reg;
        wr_data.stamp   = tick_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    req_width_next = clamped;
                    if (req_type == REQ_CLEAR)
                    begin
                        valid_next = '0;
                        tick_next  = '0;
                        res_next   = '0;
                        res_next.width_used  = clamped;
                        res_next.height_used = clamped[WIDTH_W-1:1];
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        tick_next       = tick_reg + 1'b1;
                        req_map_next    = map_select;
                        req_kind_next   = surface_kind;
                        req_seed_next   = seed;
                        issue_next      = '0;
                        first_pass_next = 1'b1;
                        found_next      = 1'b0;
                        count_next      = '0;
                        free_found_next = 1'b0;
                        old_found_next  = 1'b0;
                        hit_next        = 1'b0;
                        evicted_next    = 1'b0;
                        state_next      = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                if (issue_reg != SLOTS_IW)
                begin
                    rd_en         = 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = issue_reg[IDX_W-1:0];
                    issue_next    = issue_reg + 1'b1;
                end

                // Check the slot whose data arrived from the store this cycle.
                if (pend_reg)
                begin
                    if (first_pass_reg)
                    begin
                        if (slot_in_map && !found_reg && rd_data.kind == req_kind_reg &&
                            rd_data.seed == req_seed_reg && rd_data.width == req_width_reg)
                        begin
                            found_next     = 1'b1;
                            found_idx_next = pend_idx_reg;
                        end
                        if (slot_in_map)
                        begin
                            count_next = count_reg + 1'b1;
                        end
                        if (!valid_reg[pend_idx_reg] && !free_found_reg)
                        begin
                            free_found_next = 1'b1;
                            free_idx_next   = pend_idx_reg;
                        end
                    end
                    // Strict compare keeps the lowest slot on equal stamps.
                    if (slot_in_map && (!old_found_reg || rd_data.stamp < old_stamp_reg))
                    begin
                        old_found_next = 1'b1;
                        old_idx_next   = pend_idx_reg;
                        old_stamp_next = rd_data.stamp;
                    end
                end

                if (scan_end)
                begin
                    if (first_pass_reg && found_reg)
                    begin
                        hit_next    = 1'b1;
                        target_next = found_idx_reg;
                        state_next  = ST_WRITE;
                    end
                    else if (limit == '0)
                    begin
                        valid_next = valid_reg & (map_reg ^ {STORE_SLOTS{req_map_reg}});
                        res_next   = '0;
                        res_next.width_used  = req_width_reg;
                        res_next.height_used = req_width_reg[WIDTH_W-1:1];
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else if (count_reg >= limit && old_found_reg)
                    begin
                        valid_next[old_idx_reg] = 1'b0;
                        count_next = count_reg - 1'b1;
                        if (!evicted_reg)
                        begin
                            evicted_next = 1'b1;
                            target_next  = old_idx_reg;
                        end
                        if (count_reg > limit)
                        begin
                            // Still over the limit: scan again for the next oldest.
                            issue_next      = '0;
                            first_pass_next = 1'b0;
                            old_found_next  = 1'b0;
                        end
                        else
                        begin
                            state_next = ST_WRITE;
                        end
                    end
                    else if (evicted_reg)
                    begin
                        state_next = ST_WRITE;
                    end
                    else if (free_found_reg)
                    begin
                        target_next = free_idx_reg;
                        state_next  = ST_WRITE;
                    end
                    else
                    begin
                        res_next   = '0;
                        res_next.width_used  = req_width_reg;
                        res_next.height_used = req_width_reg[WIDTH_W-1:1];
                        done_next  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_WRITE:
            begin
                wr_en = 1'b1;
                if (!hit_reg)
                begin
                    valid_next[target_reg] = 1'b1;
                    map_next[target_reg]   = req_map_reg;
                end
                res_next.hit          = hit_reg;
                res_next.slot         = OUT_SLOT_W'(target_reg);
                res_next.kept         = 1'b1;
                res_next.evicted      = evicted_reg;
                res_next.evicted_slot = evicted_reg ? OUT_SLOT_W'(target_reg) : '0;
                res_next.width_used   = req_width_reg;
                res_next.height_used  = req_width_reg[WIDTH_W-1:1];
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= '0;
            tick_reg  <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            tick_reg  <= tick_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        map_reg        <= map_next;
        req_map_reg    <= req_map_next;
        req_kind_reg   <= req_kind_next;
        req_seed_reg   <= req_seed_next;
        req_width_reg  <= req_width_next;
        issue_reg      <= issue_next;
        pend_idx_reg   <= pend_idx_next;
        first_pass_reg <= first_pass_next;
        found_reg      <= found_next;
        found_idx_reg  <= found_idx_next;
        count_reg      <= count_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        old_found_reg  <= old_found_next;
        old_idx_reg    <= old_idx_next;
        old_stamp_reg  <= old_stamp_next;
        hit_reg        <= hit_next;
        evicted_reg    <= evicted_next;
        target_reg     <= target_next;
        res_reg        <= res_next;
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign res  = res_reg;

endmodule
`default_nettype wire

@@ src/lru_keyed_entry_cache_core.sv @@
`default_nettype none
// Lookup: busy until done; the scan reads one slot per cycle, with the read data registered
// in the store; the scan end decides, then a write state stores or stamps the entry.
// A miss that stores nothing ends at the decision, without the write state. Each extra
// eviction needed after max_entries is lowered adds a rescan of the whole store.
// Clear: handled while idle. done rises in the cycle after the request completes; the receiver
// cannot stall. Reset clears all valid bits and the use tick, sets the limit register to 16.
// ----------------------------------------------------------------------------
// LRU keyed entry cache core
// Fully associative two-map cache directory with per-map LRU replacement.
// ----------------------------------------------------------------------------
module lru_keyed_entry_cache_core #(
    parameter int STORE_SLOTS = lkc_pkg::SLOTS_DEFAULT
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic                                 req_type,
    input  wire logic                                 map_select,
    input  wire logic [lkc_pkg::KIND_W-1:0]           surface_kind,
    input  wire logic [lkc_pkg::SEED_W-1:0]           seed,
    input  wire logic [lkc_pkg::WIDTH_IN_W-1:0]       width_px,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [lkc_pkg::CFG_W-1:0]            cfg_data,
    output logic                                      done,
    output logic                                      hit,
    output logic [lkc_pkg::OUT_SLOT_W-1:0]            slot,
    output logic                                      kept,
    output logic                                      evicted,
    output logic [lkc_pkg::OUT_SLOT_W-1:0]            evicted_slot,
    output logic [lkc_pkg::WIDTH_W-1:0]               width_used,
    output logic [lkc_pkg::HEIGHT_W-1:0]              height_used
);
    import lkc_pkg::*;

    localparam int IDX_W = $clog2(STORE_SLOTS);

    logic [CFG_W-1:0] max_entries_reg, max_entries_next;
    result_t          res;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    entry_t           rd_data;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    entry_t           wr_data;

    assign cfg_ready        = 1'b1;
    assign max_entries_next = (cfg_valid && cfg_ready) ? cfg_data : max_entries_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_entries_reg <= MAX_ENTRIES_RESET;
        end
        else
        begin
            max_entries_reg <= max_entries_next;
        end
    end

    lkc_ctrl #(
        .STORE_SLOTS (STORE_SLOTS),
        .IDX_W       (IDX_W)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .map_select   (map_select),
        .surface_kind (surface_kind),
        .seed         (seed),
        .width_px     (width_px),
        .max_entries  (max_entries_reg),
        .done         (done),
        .res          (res),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data)
    );

    lkc_store #(
        .STORE_SLOTS (STORE_SLOTS),
        .IDX_W       (IDX_W)
    ) u_store (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    assign hit          = res.hit;
    assign slot         = res.slot;
    assign kept         = res.kept;
    assign evicted      = res.evicted;
    assign evicted_slot = res.evicted_slot;
    assign width_used   = res.width_used;
    assign height_used  = res.height_used;

endmodule
`default_nettype wire

@@ tb/tb_lru_keyed_entry_cache_core.sv @@
// ----------------------------------------------------------------------------
// Testbench for the LRU keyed entry cache core
// Sends lookup and clear requests through the start/busy handshake and
// checks every done pulse against a cycle-free model of the two-map
// directory. The model keeps its own slot store, use tick and entry limit.
// Directed tests cover width clamping, hits, clears and each limit rule.
// Random phases then reuse a key pool under several limits and sender gaps.
// ----------------------------------------------------------------------------
module tb_lru_keyed_entry_cache_core;
    import lkc_pkg::*;

    localparam int NSLOTS    = SLOTS_DEFAULT;
    localparam int POOL_SIZE = 24;

    typedef struct {
        bit         mp;
        bit [7:0]   kd;
        bit [63:0]  sd;
        bit [15:0]  wpx;
    } cache_key_t;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic                  req_type;
    logic                  map_select;
    logic [KIND_W-1:0]     surface_kind;
    logic [SEED_W-1:0]     seed;
    logic [WIDTH_IN_W-1:0] width_px;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_W-1:0]      cfg_data;
    logic                  done;
    logic                  hit;
    logic [OUT_SLOT_W-1:0] slot;
    logic                  kept;
    logic                  evicted;
    logic [OUT_SLOT_W-1:0] evicted_slot;
    logic [WIDTH_W-1:0]    width_used;
    logic [HEIGHT_W-1:0]   height_used;

    // Model of the directory.
    bit        slot_valid [NSLOTS];
    bit        slot_map   [NSLOTS];
    bit [7:0]  slot_kind  [NSLOTS];
    bit [63:0] slot_seed  [NSLOTS];
    bit [11:0] slot_width [NSLOTS];
    bit [63:0] slot_stamp [NSLOTS];
    bit [63:0] use_tick;
    bit [4:0]  max_entries_reg;

    result_t    pending_results[$];
    cache_key_t key_pool[POOL_SIZE];

    int error_count;
    int results_checked;
    int hits_seen;
    int evictions_seen;
    int clears_sent;
    int requests_sent;

    lru_keyed_entry_cache_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req_type     (req_type),
        .map_select   (map_select),
        .surface_kind (surface_kind),
        .seed         (seed),
        .width_px     (width_px),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .done         (done),
        .hit          (hit),
        .slot         (slot),
        .kept         (kept),
        .evicted      (evicted),
        .evicted_slot (evicted_slot),
        .width_used   (width_used),
        .height_used  (height_used)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("FAIL lru_keyed_entry_cache_core");
        $finish;
    end

    function automatic result_t predict_request(bit rq, bit mp, bit [7:0] kd, bit [63:0] sd,
                                                bit [15:0] wpx);
        result_t   r;
        bit [11:0] wc;
        int        found;
        int        free_idx;
        int        count;
        int        oldest;
        int        eff_limit;
        bit [63:0] oldest_stamp;
        if (wpx < WIDTH_MIN)
            wc = 12'd64;
        else if (wpx > WIDTH_MAX)
            wc = 12'd2048;
        else
            wc = wpx[11:0];
        r = '0;
        r.width_used  = wc;
        r.height_used = wc[11:1];
        if (rq == REQ_CLEAR)
        begin
            for (int i = 0; i < NSLOTS; i++)
                slot_valid[i] = 1'b0;
            use_tick = '0;
            return r;
        end
        use_tick++;
        found = -1;
        for (int i = 0; i < NSLOTS; i++)
            if (found < 0 && slot_valid[i] && slot_map[i] == mp && slot_kind[i] == kd &&
                slot_seed[i] == sd && slot_width[i] == wc)
                found = i;
        if (found >= 0)
        begin
            slot_stamp[found] = use_tick;
            r.hit  = 1'b1;
            r.kept = 1'b1;
            r.slot = found[4:0];
            return r;
        end
        eff_limit = (max_entries_reg > NSLOTS / 2) ? NSLOTS / 2 : max_entries_reg;
        if (eff_limit == 0)
        begin
            // A zero limit flushes the whole map and stores nothing.
            for (int i = 0; i < NSLOTS; i++)
                if (slot_valid[i] && slot_map[i] == mp)
                    slot_valid[i] = 1'b0;
            return r;
        end
        count = 0;
        for (int i = 0; i < NSLOTS; i++)
            if (slot_valid[i] && slot_map[i] == mp)
                count++;
        free_idx = -1;
        // After the limit is lowered several entries go; the first one removed is reused.
        while (count >= eff_limit)
        begin
            oldest = -1;
            oldest_stamp = '0;
            for (int i = 0; i < NSLOTS; i++)
                if (slot_valid[i] && slot_map[i] == mp &&
                    (oldest < 0 || slot_stamp[i] < oldest_stamp))
                begin
                    oldest = i;
                    oldest_stamp = slot_stamp[i];
                end
            if (oldest < 0)
                break;
            slot_valid[oldest] = 1'b0;
            if (!r.evicted)
            begin
                r.evicted      = 1'b1;
                r.evicted_slot = oldest[4:0];
                free_idx       = oldest;
            end
            count--;
        end
        if (free_idx < 0)
            for (int i = 0; i < NSLOTS; i++)
                if (free_idx < 0 && !slot_valid[i])
                    free_idx = i;
        if (free_idx >= 0)
        begin
            slot_valid[free_idx] = 1'b1;
            slot_map[free_idx]   = mp;
            slot_kind[free_idx]  = kd;
            slot_seed[free_idx]  = sd;
            slot_width[free_idx] = wc;
            slot_stamp[free_idx] = use_tick;
            r.kept = 1'b1;
            r.slot = free_idx[4:0];
        end
        return r;
    endfunction

    // Checks each result in the cycle in which done is high.
    always @(posedge clk)
    begin
        result_t seen;
        result_t want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            seen = {hit, slot, kept, evicted, evicted_slot, width_used, height_used};
            if (pending_results.size() == 0)
            begin
                error_count++;
                if (error_count <= 10)
                    $display("unexpected result with no request outstanding: %p", seen);
            end
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                if (seen.hit === 1'b1)
                    hits_seen++;
                if (seen.evicted === 1'b1)
                    evictions_seen++;
                if (seen.hit !== want.hit || seen.slot !== want.slot ||
                    seen.kept !== want.kept || seen.evicted !== want.evicted ||
                    seen.evicted_slot !== want.evicted_slot ||
                    seen.width_used !== want.width_used ||
                    seen.height_used !== want.height_used)
                begin
                    error_count++;
                    if (error_count <= 10)
                        $display({"result %0d mismatch (expected/actual): hit %0d/%0d ",
                                  "slot %0d/%0d kept %0d/%0d evicted %0d/%0d ",
                                  "evicted_slot %0d/%0d width %0d/%0d height %0d/%0d"},
                                 results_checked, want.hit, seen.hit, want.slot, seen.slot,
                                 want.kept, seen.kept, want.evicted, seen.evicted,
                                 want.evicted_slot, seen.evicted_slot,
                                 want.width_used, seen.width_used,
                                 want.height_used, seen.height_used);
                end
            end
        end
    end

    // Presents one request and returns once it has been accepted.
    task automatic issue_request(bit rq, bit mp, bit [7:0] kd, bit [63:0] sd, bit [15:0] wpx);
        req_type     <= rq;
        map_select   <= mp;
        surface_kind <= kd;
        seed         <= sd;
        width_px     <= wpx;
        start        <= 1'b1;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        pending_results.push_back(predict_request(rq, mp, kd, sd, wpx));
        requests_sent++;
        if (rq == REQ_CLEAR)
            clears_sent++;
    endtask

    task automatic idle_sender(int pct);
        int gap;
        if ($urandom_range(0, 99) < pct)
        begin
            // Gaps longer than one scan leave the block idle between requests.
            gap = $urandom_range(1, 50);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic settle();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_max_entries(bit [4:0] value);
        settle();
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        max_entries_reg = value;
    endtask

    function automatic bit [15:0] random_width();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 63));
            2: return 16'($urandom_range(64, 2048));
            default: return 16'($urandom_range(2049, 65535));
        endcase
    endfunction

    // Another raw width that clamps to the same key width.
    function automatic bit [15:0] equivalent_width(bit [15:0] wpx);
        if (wpx <= WIDTH_MIN)
            return 16'($urandom_range(0, 64));
        if (wpx >= WIDTH_MAX)
            return 16'($urandom_range(2048, 65535));
        return wpx;
    endfunction

    function automatic cache_key_t random_key();
        cache_key_t k;
        k.mp  = 1'($urandom);
        k.kd  = 8'($urandom);
        case ($urandom_range(0, 7))
            0: k.sd = '0;
            1: k.sd = '1;
            default: k.sd = {$urandom, $urandom};
        endcase
        k.wpx = random_width();
        return k;
    endfunction

    task automatic test_basic_lookup();
        issue_request(REQ_LOOKUP, 1'b0, 8'd0, 64'd0, 16'd0);
        issue_request(REQ_LOOKUP, 1'b0, 8'd0, 64'd0, 16'd63);
        issue_request(REQ_LOOKUP, 1'b0, 8'd0, 64'd0, 16'd64);
        issue_request(REQ_LOOKUP, 1'b1, 8'hFF, '1, 16'hFFFF);
        issue_request(REQ_LOOKUP, 1'b1, 8'hFF, '1, 16'd2048);
        issue_request(REQ_LOOKUP, 1'b1, 8'hFF, '1, 16'd2049);
        issue_request(REQ_LOOKUP, 1'b1, 8'hFF, '1, 16'd2047);
        issue_request(REQ_LOOKUP, 1'b0, 8'h5A, 64'hA5A5_5A5A_F00F_0FF0, 16'd1000);
        issue_request(REQ_LOOKUP, 1'b1, 8'h5A, 64'hA5A5_5A5A_F00F_0FF0, 16'd1000);
        issue_request(REQ_CLEAR, 1'b1, 8'hFF, '1, 16'hFFFF);
        issue_request(REQ_CLEAR, 1'b0, 8'd0, 64'd0, 16'd100);
        issue_request(REQ_LOOKUP, 1'b0, 8'd0, 64'd0, 16'd0);
        settle();
    endtask

    task automatic test_lru_eviction();
        write_max_entries(5'd2);
        issue_request(REQ_LOOKUP, 1'b0, 8'd1, 64'h11, 16'd128);
        issue_request(REQ_LOOKUP, 1'b0, 8'd2, 64'h22, 16'd128);
        issue_request(REQ_LOOKUP, 1'b0, 8'd1, 64'h11, 16'd128);
        issue_request(REQ_LOOKUP, 1'b0, 8'd3, 64'h33, 16'd128);
        issue_request(REQ_LOOKUP, 1'b1, 8'd4, 64'h44, 16'd128);
        issue_request(REQ_LOOKUP, 1'b0, 8'd2, 64'h22, 16'd128);
        settle();
    endtask

    task automatic test_lowered_limit();
        write_max_entries(5'd16);
        for (int i = 1; i <= 5; i++)
            issue_request(REQ_LOOKUP, 1'b1, 8'(i), 64'(i) << 40, 16'd512);
        // The map now holds more than the new limit, so one miss removes several entries.
        write_max_entries(5'd1);
        issue_request(REQ_LOOKUP, 1'b1, 8'd9, 64'h99, 16'd512);
        settle();
    endtask

    task automatic test_zero_limit();
        write_max_entries(5'd0);
        issue_request(REQ_LOOKUP, 1'b1, 8'd9, 64'h99, 16'd512);
        issue_request(REQ_LOOKUP, 1'b0, 8'd7, 64'h77, 16'd300);
        issue_request(REQ_LOOKUP, 1'b0, 8'd2, 64'h22, 16'd128);
        settle();
    endtask

    task automatic test_random_phase(bit [4:0] limit, int idle_pct, int n_items);
        cache_key_t k;
        int         pick;
        int         choice;
        write_max_entries(limit);
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = random_key();
        for (int n = 0; n < n_items; n++)
        begin
            choice = $urandom_range(0, 99);
            if (choice < 3)
            begin
                k = random_key();
                issue_request(REQ_CLEAR, k.mp, k.kd, k.sd, k.wpx);
            end
            else if (choice < 63)
            begin
                pick = $urandom_range(0, POOL_SIZE - 1);
                k = key_pool[pick];
                issue_request(REQ_LOOKUP, k.mp, k.kd, k.sd, equivalent_width(k.wpx));
            end
            else
            begin
                k = random_key();
                if ($urandom_range(0, 1))
                    key_pool[$urandom_range(0, POOL_SIZE - 1)] = k;
                issue_request(REQ_LOOKUP, k.mp, k.kd, k.sd, k.wpx);
            end
            idle_sender(idle_pct);
        end
        settle();
    endtask

    initial
    begin
        rst_n        <= 1'b0;
        start        <= 1'b0;
        req_type     <= REQ_LOOKUP;
        map_select   <= 1'b0;
        surface_kind <= '0;
        seed         <= '0;
        width_px     <= '0;
        cfg_valid    <= 1'b0;
        cfg_data     <= '0;
        for (int i = 0; i < NSLOTS; i++)
        begin
            slot_valid[i] = 1'b0;
            slot_map[i]   = 1'b0;
            slot_kind[i]  = '0;
            slot_seed[i]  = '0;
            slot_width[i] = '0;
            slot_stamp[i] = '0;
        end
        use_tick        = '0;
        max_entries_reg = MAX_ENTRIES_RESET;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_lookup();
        test_lru_eviction();
        test_lowered_limit();
        test_zero_limit();
        test_random_phase(5'd31, 0, 180);
        test_random_phase(5'd16, 54, 170);
        test_random_phase(5'd3, 24, 170);
        test_random_phase(5'd0, 0, 120);
        test_random_phase(5'd1, 54, 120);
        test_random_phase(5'd8, 24, 180);

        repeat (50) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            error_count += pending_results.size();
            $display("%0d results never arrived", pending_results.size());
        end
        $display("Sent %0d requests (%0d clears) and checked %0d results: %0d hits, %0d evictions.",
                 requests_sent, clears_sent, results_checked, hits_seen, evictions_seen);
        $display("Limits 0, 1, 2, 3, 8, 16 and 31 were used with sender gaps of 0, 24 and 54 percent.");
        if (error_count == 0)
            $display("PASS lru_keyed_entry_cache_core");
        else
            $display("FAIL lru_keyed_entry_cache_core");
        $finish;
    end

endmodule

@@ filelist.f @@
src/lkc_pkg.sv
src/lkc_store.sv
src/lkc_ctrl.sv
src/lru_keyed_entry_cache_core.sv
tb/tb_lru_keyed_entry_cache_core.sv
